[rtl/pdffvc_pkg.sv]
// Shared constants, codes and control types of the PD feedforward velocity controller.
`default_nettype none

package pdffvc_pkg;

   localparam int SPEED_BITS_DEF = 16;
   localparam int ELAPSED_BITS   = 20;
   localparam int GAIN_BITS      = 16;
   localparam int FRAC_GAIN      = 8;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_IDX_BITS   = 2;
   localparam int US_PER_S       = 1000000;
   // Second multiplier operand: holds US_PER_S and a zero-extended gain as signed
   localparam int MUL_B_BITS     = 21;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GAIN_P_ANG = 2'd0,
      CSR_GAIN_D_ANG = 2'd1,
      CSR_GAIN_P_LIN = 2'd2,
      CSR_GAIN_D_LIN = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NUM,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DERIV,
      ST_MUL_P,
      ST_MUL_D,
      ST_ACC_D,
      ST_ROUND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic mul_num;
      logic div_init;
      logic div_step;
      logic deriv;
      logic mul_p;
      logic mul_d;
      logic acc_d;
      logic round;
      logic out_load;
      logic ch;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

`default_nettype wire

[rtl/pdffvc_dp.sv]
// Datapath: gain registers, speed history, shared multiplier, serial divider, accumulator.
`default_nettype none

module pdffvc_dp #(
   parameter int SPEED_BITS = pdffvc_pkg::SPEED_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [pdffvc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [pdffvc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic signed [SPEED_BITS-1:0]           req_meas_ang_speed,
   input  wire logic signed [SPEED_BITS-1:0]           req_want_ang_speed,
   input  wire logic signed [SPEED_BITS-1:0]           req_meas_lin_speed,
   input  wire logic signed [SPEED_BITS-1:0]           req_want_lin_speed,
   input  wire logic [pdffvc_pkg::ELAPSED_BITS-1:0]    req_elapsed_us,
   input  wire pdffvc_pkg::cmd_type                    cmd,
   output pdffvc_pkg::sts_type                         sts,
   output logic signed [SPEED_BITS-1:0]                rsp_drive_ang,
   output logic signed [SPEED_BITS-1:0]                rsp_drive_lin,
   output logic                                        rsp_clipped
);
   import pdffvc_pkg::*;

   localparam int SB     = SPEED_BITS;
   localparam int MA_W   = SB + 2;
   localparam int PROD_W = MA_W + MUL_B_BITS;
   localparam int NUM_W  = SB + 1 + ELAPSED_BITS;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int ACC_W  = SB + 20;
   localparam int SHW    = ACC_W - FRAC_GAIN;

   logic [GAIN_BITS-1:0]       kp_ff [2];
   logic [GAIN_BITS-1:0]       kd_ff [2];
   logic signed [SB-1:0]       last_ff [2];
   logic                       seen_ff;
   logic signed [SB:0]         err_ff [2];
   logic signed [SB:0]         diff_ff [2];
   logic signed [SB-1:0]       want_ff [2];
   logic signed [SB-1:0]       drive_ff [2];
   logic                       use_ff;
   logic                       flag_ff;
   logic [ELAPSED_BITS-1:0]    el_ff;
   logic signed [PROD_W-1:0]   mul_ff;
   logic [NUM_W-1:0]           quo_ff;
   logic [ELAPSED_BITS-1:0]    rem_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [SB-1:0]       deriv_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [SB-1:0]       out_ang_ff;
   logic signed [SB-1:0]       out_lin_ff;
   logic                       out_clip_ff;

   logic signed [SB:0]         diff_sel;
   logic [SB:0]                mag;
   logic signed [MA_W-1:0]     mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic [ELAPSED_BITS:0]      trial;
   logic [ELAPSED_BITS:0]      trial_sub;
   logic                       trial_ge;
   logic signed [SB-1:0]       deriv_val;
   logic                       deriv_clip;
   logic signed [ACC_W-1:0]    rnd;
   logic signed [SHW-1:0]      shv;
   logic [SHW-SB:0]            shv_hi;
   logic signed [SB-1:0]       drive_val;
   logic                       drive_clip;
   logic signed [SB-1:0]       smax;
   logic signed [SB-1:0]       smin;

   assign smax = {1'b0, {(SB-1){1'b1}}};
   assign smin = {1'b1, {(SB-1){1'b0}}};

   // Magnitude of the speed change of the selected channel
   assign diff_sel = diff_ff[cmd.ch];
   assign mag      = diff_sel[SB] ? (~diff_sel + 1'b1) : diff_sel;

   // Shared multiplier operand selection
   always_comb begin
      mul_a = MA_W'(err_ff[cmd.ch]);
      mul_b = MUL_B_BITS'(kp_ff[cmd.ch]);
      if (cmd.mul_num) begin
         mul_a = {1'b0, mag};
         mul_b = MUL_B_BITS'(US_PER_S);
      end else if (cmd.mul_d) begin
         mul_a = MA_W'(deriv_ff);
         mul_b = MUL_B_BITS'(kd_ff[cmd.ch]);
      end
   end

   // One restoring division step
   assign trial     = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_ge  = trial >= {1'b0, el_ff};
   assign trial_sub = trial - {1'b0, el_ff};

   // Derivative saturation from the unsigned quotient and the sign of the change
   always_comb begin
      deriv_val  = '0;
      deriv_clip = 1'b0;
      if (use_ff) begin
         if (diff_sel[SB]) begin
            if ((|quo_ff[NUM_W-1:SB]) || (quo_ff[SB-1] && (|quo_ff[SB-2:0]))) begin
               deriv_val  = smin;
               deriv_clip = 1'b1;
            end else begin
               deriv_val = -$signed(quo_ff[SB-1:0]);
            end
         end else begin
            if (|quo_ff[NUM_W-1:SB-1]) begin
               deriv_val  = smax;
               deriv_clip = 1'b1;
            end else begin
               deriv_val = $signed(quo_ff[SB-1:0]);
            end
         end
      end
   end

   // Round to nearest (ties up), drop the gain fraction, saturate
   assign rnd    = acc_ff + ACC_W'(1 << (FRAC_GAIN - 1));
   assign shv    = rnd[ACC_W-1:FRAC_GAIN];
   assign shv_hi = shv[SHW-1:SB-1];

   always_comb begin
      drive_val  = shv[SB-1:0];
      drive_clip = 1'b0;
      if (!((&shv_hi) || !(|shv_hi))) begin
         drive_clip = 1'b1;
         drive_val  = shv[SHW-1] ? smin : smax;
      end
   end

   assign sts.div_last = (cnt_ff == CNT_W'(NUM_W - 1));

   // Gains, history and seen flag
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff[0]   <= '0;
         kp_ff[1]   <= '0;
         kd_ff[0]   <= '0;
         kd_ff[1]   <= '0;
         last_ff[0] <= '0;
         last_ff[1] <= '0;
         seen_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_idx_type'(csr_index))
               CSR_GAIN_P_ANG: kp_ff[0] <= csr_wdata;
               CSR_GAIN_D_ANG: kd_ff[0] <= csr_wdata;
               CSR_GAIN_P_LIN: kp_ff[1] <= csr_wdata;
               CSR_GAIN_D_LIN: kd_ff[1] <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load_in) begin
            last_ff[0] <= req_meas_ang_speed;
            last_ff[1] <= req_meas_lin_speed;
            seen_ff    <= 1'b1;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         err_ff[0]  <= (SB+1)'(req_meas_ang_speed) - (SB+1)'(req_want_ang_speed);
         err_ff[1]  <= (SB+1)'(req_meas_lin_speed) - (SB+1)'(req_want_lin_speed);
         diff_ff[0] <= (SB+1)'(req_meas_ang_speed) - (SB+1)'(last_ff[0]);
         diff_ff[1] <= (SB+1)'(req_meas_lin_speed) - (SB+1)'(last_ff[1]);
         want_ff[0] <= req_want_ang_speed;
         want_ff[1] <= req_want_lin_speed;
         use_ff     <= seen_ff && (req_elapsed_us != '0);
         el_ff      <= req_elapsed_us;
         flag_ff    <= 1'b0;
      end
      if (cmd.mul_num || cmd.mul_p || cmd.mul_d) begin
         mul_ff <= mul_a * mul_b;
      end
      if (cmd.div_init) begin
         quo_ff <= mul_ff[NUM_W-1:0];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[NUM_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_sub[ELAPSED_BITS-1:0] : trial[ELAPSED_BITS-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.deriv) begin
         deriv_ff <= deriv_val;
         acc_ff   <= {(ACC_W-FRAC_GAIN)'(want_ff[cmd.ch]), {FRAC_GAIN{1'b0}}};
         if (deriv_clip) begin
            flag_ff <= 1'b1;
         end
      end
      if (cmd.mul_d) begin
         acc_ff <= acc_ff - mul_ff[ACC_W-1:0];
      end
      if (cmd.acc_d) begin
         acc_ff <= acc_ff + mul_ff[ACC_W-1:0];
      end
      if (cmd.round) begin
         drive_ff[cmd.ch] <= drive_val;
         if (drive_clip) begin
            flag_ff <= 1'b1;
         end
      end
      if (cmd.out_load) begin
         out_ang_ff  <= drive_ff[0];
         out_lin_ff  <= drive_ff[1];
         out_clip_ff <= flag_ff;
      end
   end

   assign rsp_drive_ang = out_ang_ff;
   assign rsp_drive_lin = out_lin_ff;
   assign rsp_clipped   = out_clip_ff;

endmodule

`default_nettype wire

[rtl/pdffvc_ctrl.sv]
// Controller: sequences both channels through the datapath and owns the handshakes.
`default_nettype none

module pdffvc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output pdffvc_pkg::cmd_type       cmd,
   input  wire pdffvc_pkg::sts_type  sts
);
   import pdffvc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      ch_ff;
   logic      ch_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Hold the input stalled during reset and while a transaction is in flight
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_NUM;
               ch_in    = 1'b0;
            end
         end
         ST_MUL_NUM:  state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV_STEP;
         ST_DIV_STEP: begin
            if (sts.div_last) begin
               state_in = ST_DERIV;
            end
         end
         ST_DERIV:    state_in = ST_MUL_P;
         ST_MUL_P:    state_in = ST_MUL_D;
         ST_MUL_D:    state_in = ST_ACC_D;
         ST_ACC_D:    state_in = ST_ROUND;
         ST_ROUND: begin
            if (ch_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL_NUM;
               ch_in    = 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd    = '0;
      cmd.ch = ch_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.load_in  = req_valid;
         ST_MUL_NUM:  cmd.mul_num  = 1'b1;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV_STEP: cmd.div_step = 1'b1;
         ST_DERIV:    cmd.deriv    = 1'b1;
         ST_MUL_P:    cmd.mul_p    = 1'b1;
         ST_MUL_D:    cmd.mul_d    = 1'b1;
         ST_ACC_D:    cmd.acc_d    = 1'b1;
         ST_ROUND:    cmd.round    = 1'b1;
         ST_OUT:      cmd.out_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/pd_feedforward_velocity_controller_top.sv]
// Top level of the two-channel PD velocity controller with feedforward.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   req     | in        | req_valid/req_stall| meas/want speeds (ang, lin), elapsed_us
//   rsp     | out       | rsp_valid/rsp_stall| drive_ang, drive_lin, clipped
//   csr     | in        | csr_wr_en          | csr_index, csr_wdata (gains, Q8.8)
//
// One transaction at a time. Each channel runs one multiply by 1e6, one load
// and SPEED_BITS + 21 steps of the serial divider, then derivative clamp, two
// gain multiplies on the shared multiplier, accumulation and rounding. A
// transaction also has an accept and a result step; the divider dominates.
// Reset clears gains, speed history and handshake state.
// The result register frees the input side: a new request is taken while a
// stalled result waits; the next result holds in the controller until it drains.
`default_nettype none

module pd_feedforward_velocity_controller_top #(
   parameter int SPEED_BITS = pdffvc_pkg::SPEED_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [pdffvc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [pdffvc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [SPEED_BITS-1:0]           req_meas_ang_speed,
   input  wire logic signed [SPEED_BITS-1:0]           req_want_ang_speed,
   input  wire logic signed [SPEED_BITS-1:0]           req_meas_lin_speed,
   input  wire logic signed [SPEED_BITS-1:0]           req_want_lin_speed,
   input  wire logic [pdffvc_pkg::ELAPSED_BITS-1:0]    req_elapsed_us,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [SPEED_BITS-1:0]                rsp_drive_ang,
   output logic signed [SPEED_BITS-1:0]                rsp_drive_lin,
   output logic                                        rsp_clipped
);
   import pdffvc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer: handshakes, channel select, per-step commands
   pdffvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Arithmetic: gains, history, multiplier, divider, result register
   pdffvc_dp #(
      .SPEED_BITS (SPEED_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_meas_ang_speed (req_meas_ang_speed),
      .req_want_ang_speed (req_want_ang_speed),
      .req_meas_lin_speed (req_meas_lin_speed),
      .req_want_lin_speed (req_want_lin_speed),
      .req_elapsed_us     (req_elapsed_us),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_drive_ang      (rsp_drive_ang),
      .rsp_drive_lin      (rsp_drive_lin),
      .rsp_clipped        (rsp_clipped)
   );

endmodule

`default_nettype wire

[verif/pd_feedforward_velocity_controller_top_test.sv]
// Self-checking testbench for the two-channel PD feedforward velocity controller.
`timescale 1ns / 1ps

module pd_feedforward_velocity_controller_top_test;
   import pdffvc_pkg::*;

   localparam int SB             = SPEED_BITS_DEF;
   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 10;
   // Longer than one whole transaction, to leave some margin on top
   localparam int SETTLE_CYCLES  = 2 * SB + 70;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRILL_ROWS     = 17;
   localparam int NUM_SEGS       = 8;
   localparam int SEG_ITEMS      = 200;

   localparam logic [SB-1:0]           SPEED_MAX   = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0]           SPEED_MIN   = {1'b1, {(SB-1){1'b0}}};
   localparam logic [GAIN_BITS-1:0]    GAIN_MAX    = '1;
   localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

   // One request transaction: both channels' speeds plus elapsed time
   typedef struct packed {
      logic [SB-1:0]           meas_ang;
      logic [SB-1:0]           want_ang;
      logic [SB-1:0]           meas_lin;
      logic [SB-1:0]           want_lin;
      logic [ELAPSED_BITS-1:0] elapsed;
   } speed_request_type;

   typedef struct packed {
      logic [SB-1:0] drive_ang;
      logic [SB-1:0] drive_lin;
      logic          clipped;
   } drive_result_type;

   // Directed row: optional gain load before the request, optional hand-written result
   typedef struct packed {
      logic                 load_gains;
      logic [GAIN_BITS-1:0] kp_ang;
      logic [GAIN_BITS-1:0] kd_ang;
      logic [GAIN_BITS-1:0] kp_lin;
      logic [GAIN_BITS-1:0] kd_lin;
      speed_request_type    req;
      logic                 typed;
      drive_result_type     fixed;
   } drill_row_type;

   logic                          clock              = 1'b0;
   logic                          reset              = 1'b1;
   logic                          csr_wr_en          = 1'b0;
   csr_idx_type                   csr_index          = CSR_GAIN_P_ANG;
   logic [CSR_DATA_BITS-1:0]      csr_wdata          = '0;
   logic                          req_valid          = 1'b0;
   logic                          req_stall;
   logic signed [SB-1:0]          req_meas_ang_speed = '0;
   logic signed [SB-1:0]          req_want_ang_speed = '0;
   logic signed [SB-1:0]          req_meas_lin_speed = '0;
   logic signed [SB-1:0]          req_want_lin_speed = '0;
   logic [ELAPSED_BITS-1:0]       req_elapsed_us     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall          = 1'b0;
   logic signed [SB-1:0]          rsp_drive_ang;
   logic signed [SB-1:0]          rsp_drive_lin;
   logic                          rsp_clipped;

   // Controller copy used for prediction: gains and speed history
   logic [GAIN_BITS-1:0]  gain_p_ang = '0;
   logic [GAIN_BITS-1:0]  gain_d_ang = '0;
   logic [GAIN_BITS-1:0]  gain_p_lin = '0;
   logic [GAIN_BITS-1:0]  gain_d_lin = '0;
   logic signed [SB-1:0]  last_meas_ang = '0;
   logic signed [SB-1:0]  last_meas_lin = '0;
   bit                    history_valid = 1'b0;

   drive_result_type expected_drives[$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int requests_sent  = 0;
   int drives_checked = 0;
   int clipped_seen   = 0;
   int mismatches     = 0;
   int gain_loads     = 0;
   int quiet_cycles   = 0;

   // Directed rows: hand-written results only where the answer is obvious
   drill_row_type drill_rows [DRILL_ROWS] = '{
      // first transaction after reset: no rate term, zero gains pass the setpoint
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, '{SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX, 20'd1},
        1'b1, '{SPEED_MIN, SPEED_MAX, 1'b0}},
      // full-scale swing in one microsecond: rate saturates although its gain is zero
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, '{SPEED_MIN, 16'sd0, SPEED_MAX, 16'sd0, 20'd1},
        1'b1, '{16'sd0, 16'sd0, 1'b1}},
      // zero elapsed time kills the rate term
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, '{SPEED_MAX, 16'sd100, SPEED_MIN, -16'sd100, 20'd0},
        1'b1, '{16'sd100, -16'sd100, 1'b0}},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, '{16'sd0, 16'sd4096, 16'sd0, -16'sd4096, ELAPSED_MAX},
        1'b1, '{16'sd4096, -16'sd4096, 1'b0}},
      '{1'b1, 16'd256, 16'd0, 16'd0, 16'd256,
        '{16'sd4096, 16'sd2048, 16'sd1000, 16'sd1000, 20'd1000}, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
        '{16'sd4000, 16'sd4096, 16'sd1100, 16'sd1000, 20'd20000}, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
        '{-16'sd3000, -16'sd2048, 16'sd900, 16'sd1200, 20'd5000}, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
        '{-16'sd2990, -16'sd2048, 16'sd950, 16'sd1200, 20'd3}, 1'b0, '0},
      // maximum gains, opposite full-scale errors: both drives pin to the rails
      '{1'b1, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
        '{SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX, 20'd0}, 1'b1, '{SPEED_MIN, SPEED_MAX, 1'b1}},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0},
        1'b1, '{16'sd0, 16'sd0, 1'b0}},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, '{16'sd8, 16'sd4, -16'sd8, -16'sd4, 20'd0}, 1'b0, '0},
      // smallest proportional gain: half-LSB ties on both sides
      '{1'b1, 16'd1, 16'd0, 16'd1, 16'd0,
        '{16'sd228, 16'sd100, -16'sd28, 16'sd100, 20'd0}, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
        '{-16'sd228, -16'sd100, 16'sd28, -16'sd100, 20'd0}, 1'b0, '0},
      '{1'b1, 16'd0, GAIN_MAX, 16'd0, GAIN_MAX,
        '{16'sd10, 16'sd0, -16'sd10, 16'sd0, 20'd1}, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
        '{16'sd11, 16'sd0, -16'sd11, 16'sd0, ELAPSED_MAX}, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
        '{16'sd500, 16'sd400, -16'sd500, -16'sd400, 20'd1000}, 1'b0, '0},
      '{1'b1, 16'd128, 16'd32, 16'd512, 16'd16,
        '{16'sd4096, 16'sd4096, -16'sd4096, -16'sd4096, 20'd0}, 1'b0, '0}
   };

   pd_feedforward_velocity_controller_top u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_meas_ang_speed (req_meas_ang_speed),
      .req_want_ang_speed (req_want_ang_speed),
      .req_meas_lin_speed (req_meas_lin_speed),
      .req_want_lin_speed (req_want_lin_speed),
      .req_elapsed_us     (req_elapsed_us),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_ang      (rsp_drive_ang),
      .rsp_drive_lin      (rsp_drive_lin),
      .rsp_clipped        (rsp_clipped)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Clamp to the signed speed range and raise the clip flag when it bites
   function automatic longint clamp_speed(input longint v, inout bit sat);
      longint top;
      top = (longint'(1) <<< (SB - 1)) - 1;
      if (v > top) begin
         sat = 1'b1;
         return top;
      end
      if (v < -top - 1) begin
         sat = 1'b1;
         return -top - 1;
      end
      return v;
   endfunction

   // One channel: setpoint feedforward, minus kp * error, plus kd * rate of change
   function automatic longint pd_channel_drive(input longint meas, input longint want,
                                               input longint last, input longint kp,
                                               input longint kd, input longint elapsed,
                                               input bit use_rate, inout bit sat);
      longint rate;
      longint diff;
      longint mag;
      longint acc;
      rate = 0;
      if (use_rate && elapsed != 0) begin
         diff = meas - last;
         mag  = (diff < 0) ? -diff : diff;
         // truncate toward zero: divide the magnitude, then restore the sign
         mag  = (mag * longint'(US_PER_S)) / elapsed;
         rate = clamp_speed((diff < 0) ? -mag : mag, sat);
      end
      acc = (want <<< FRAC_GAIN) - kp * (meas - want) + kd * rate;
      // round half up, then floor away the 8 fractional bits
      return clamp_speed((acc + (longint'(1) <<< (FRAC_GAIN - 1))) >>> FRAC_GAIN, sat);
   endfunction

   // Work out both drives for one transaction and advance the speed history
   function automatic drive_result_type predict_drive(input speed_request_type r);
      drive_result_type res;
      bit               sat;
      sat = 1'b0;
      res.drive_ang = SB'(pd_channel_drive(longint'($signed(r.meas_ang)),
                                           longint'($signed(r.want_ang)),
                                           longint'(last_meas_ang), longint'(gain_p_ang),
                                           longint'(gain_d_ang), longint'(r.elapsed),
                                           history_valid, sat));
      res.drive_lin = SB'(pd_channel_drive(longint'($signed(r.meas_lin)),
                                           longint'($signed(r.want_lin)),
                                           longint'(last_meas_lin), longint'(gain_p_lin),
                                           longint'(gain_d_lin), longint'(r.elapsed),
                                           history_valid, sat));
      res.clipped   = sat;
      last_meas_ang = r.meas_ang;
      last_meas_lin = r.meas_lin;
      history_valid = 1'b1;
      return res;
   endfunction

   // Random speed within span of base, held inside the signed range
   function automatic logic [SB-1:0] near_speed(input int base, input int span);
      int v;
      v = base + int'($urandom_range(2 * span)) - span;
      if (v > int'($signed(SPEED_MAX))) v = int'($signed(SPEED_MAX));
      if (v < int'($signed(SPEED_MIN))) v = int'($signed(SPEED_MIN));
      return v[SB-1:0];
   endfunction

   function automatic logic [SB-1:0] pick_edge_speed();
      case ($urandom_range(3))
         0: return SPEED_MIN;
         1: return SPEED_MAX;
         2: return '0;
         default: return SB'($urandom());
      endcase
   endfunction

   // Segments 0..3 force one gain style each; later ones mix styles per register
   function automatic logic [GAIN_BITS-1:0] pick_gain(input int seg, input bit rate_gain);
      int style;
      style = (seg < 4) ? seg : int'($urandom_range(3));
      case (style)
         0: return rate_gain ? GAIN_BITS'($urandom_range(64)) : GAIN_BITS'($urandom_range(1024));
         1: return GAIN_MAX;
         2: return GAIN_BITS'($urandom());
         default: return '0;
      endcase
   endfunction

   // Mostly plausible control-loop traffic, plus full-range noise and edge values
   task automatic make_random_request(output speed_request_type r);
      int kind;
      kind = $urandom_range(99);
      if (kind < 60) begin
         r.meas_ang = near_speed(last_meas_ang, 200);
         r.want_ang = near_speed($signed(r.meas_ang), 4096);
         r.meas_lin = near_speed(last_meas_lin, 200);
         r.want_lin = near_speed($signed(r.meas_lin), 4096);
         r.elapsed  = ELAPSED_BITS'($urandom_range(50000, 2000));
      end else if (kind < 75) begin
         r.meas_ang = SB'($urandom());
         r.want_ang = SB'($urandom());
         r.meas_lin = SB'($urandom());
         r.want_lin = SB'($urandom());
         r.elapsed  = ELAPSED_BITS'($urandom());
      end else if (kind < 85) begin
         r.meas_ang = near_speed(last_meas_ang, 2000);
         r.want_ang = near_speed(0, 8192);
         r.meas_lin = near_speed(last_meas_lin, 2000);
         r.want_lin = near_speed(0, 8192);
         r.elapsed  = ($urandom_range(1) != 0) ? '0 : ELAPSED_BITS'($urandom_range(16, 1));
      end else begin
         r.meas_ang = pick_edge_speed();
         r.want_ang = pick_edge_speed();
         r.meas_lin = pick_edge_speed();
         r.want_lin = pick_edge_speed();
         case ($urandom_range(3))
            0: r.elapsed = '0;
            1: r.elapsed = ELAPSED_BITS'(1);
            2: r.elapsed = ELAPSED_MAX;
            default: r.elapsed = ELAPSED_BITS'($urandom());
         endcase
      end
   endtask

   // Write one gain register and mirror it into the predictor
   task automatic write_gain_reg(input csr_idx_type idx, input logic [GAIN_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_GAIN_P_ANG: gain_p_ang = value;
         CSR_GAIN_D_ANG: gain_d_ang = value;
         CSR_GAIN_P_LIN: gain_p_lin = value;
         CSR_GAIN_D_LIN: gain_d_lin = value;
         default: ;
      endcase
   endtask

   task automatic write_gains(input logic [GAIN_BITS-1:0] kp_a, input logic [GAIN_BITS-1:0] kd_a,
                              input logic [GAIN_BITS-1:0] kp_l, input logic [GAIN_BITS-1:0] kd_l);
      write_gain_reg(CSR_GAIN_P_ANG, kp_a);
      write_gain_reg(CSR_GAIN_D_ANG, kd_a);
      write_gain_reg(CSR_GAIN_P_LIN, kp_l);
      write_gain_reg(CSR_GAIN_D_LIN, kd_l);
      csr_wr_en <= 1'b0;
      gain_loads++;
   endtask

   // Drop valid, wait for every outstanding result, then let the datapath go quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Present one request transaction, hold it until accepted, queue its expected result
   task automatic send_request(input speed_request_type r, input bit typed,
                               input drive_result_type fixed);
      drive_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_meas_ang_speed <= r.meas_ang;
      req_want_ang_speed <= r.want_ang;
      req_meas_lin_speed <= r.meas_lin;
      req_want_lin_speed <= r.want_lin;
      req_elapsed_us     <= r.elapsed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // the predictor must see every transaction to keep its history in step
      predicted = predict_drive(r);
      expected_drives.push_back(typed ? fixed : predicted);
      requests_sent++;
   endtask

   // Stall the result channel at the rate of the current phase
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Check every accepted result against the oldest outstanding expectation
   always @(posedge clock) begin
      drive_result_type exp_drive;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction: ang %0d lin %0d clipped %0b",
                     $time, rsp_drive_ang, rsp_drive_lin, rsp_clipped);
         end else begin
            exp_drive = expected_drives.pop_front();
            drives_checked++;
            if (rsp_clipped) clipped_seen++;
            if (rsp_drive_ang !== exp_drive.drive_ang) begin
               mismatches++;
               $display("%0t: drive_ang mismatch: expected %0d, got %0d",
                        $time, $signed(exp_drive.drive_ang), rsp_drive_ang);
            end
            if (rsp_drive_lin !== exp_drive.drive_lin) begin
               mismatches++;
               $display("%0t: drive_lin mismatch: expected %0d, got %0d",
                        $time, $signed(exp_drive.drive_lin), rsp_drive_lin);
            end
            if (rsp_clipped !== exp_drive.clipped) begin
               mismatches++;
               $display("%0t: clipped mismatch: expected %0b, got %0b",
                        $time, exp_drive.clipped, rsp_clipped);
            end
         end
      end
   end

   // Watchdog: end the run when neither channel moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, expected_drives.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      speed_request_type rnd_req;
      int                seg;
      int                n;
      int                row;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: gains start at their reset value of zero
      for (row = 0; row < DRILL_ROWS; row++) begin
         if (drill_rows[row].load_gains) begin
            settle_block();
            write_gains(drill_rows[row].kp_ang, drill_rows[row].kd_ang,
                        drill_rows[row].kp_lin, drill_rows[row].kd_lin);
         end
         send_request(drill_rows[row].req, drill_rows[row].typed, drill_rows[row].fixed);
      end

      // Random part: each segment reloads the gains and picks an idling pattern
      for (seg = 0; seg < NUM_SEGS; seg++) begin
         settle_block();
         write_gains(pick_gain(seg, 1'b0), pick_gain(seg, 1'b1),
                     pick_gain(seg, 1'b0), pick_gain(seg, 1'b1));
         case (seg % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         for (n = 0; n < SEG_ITEMS; n++) begin
            make_random_request(rnd_req);
            send_request(rnd_req, 1'b0, '0);
         end
      end

      // Drain: lower valid, wait out outstanding results and the pipeline tail
      settle_block();
      rsp_stall_pct = 0;

      if (expected_drives.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time, expected_drives.size());
      end
      $display("Covered %0d requests under %0d gain settings and four idling patterns.",
               requests_sent, gain_loads);
      $display("Checked %0d results, %0d with saturation flagged; %0d mismatches.",
               drives_checked, clipped_seen, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
